### design/quick_find_label_table_macros.svh
// Assertion macros used by the label table top level.
`ifndef QUICK_FIND_LABEL_TABLE_MACROS_SVH
`define QUICK_FIND_LABEL_TABLE_MACROS_SVH

`ifndef SYNTHESIS

`define QFLT_ASSERT_IMPLIES(name, clk, rst_n, cond, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed");

`define QFLT_ASSERT_NEXT(name, clk, rst_n, cond, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");

`else

`define QFLT_ASSERT_IMPLIES(name, clk, rst_n, cond, expr)

`define QFLT_ASSERT_NEXT(name, clk, rst_n, cond, expr)

`endif

`endif

### design/qflt_pkg.sv
// Types, codes and sizes shared by the label table modules.
package qflt_pkg;

    localparam int ENTRIES = 1024;
    localparam int IDX_W   = 10;
    localparam int LABEL_W = 10;
    localparam int CNT_W   = 11;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QCNT_W  = 3;

    localparam logic [CNT_W-1:0] ENTRIES_CNT = CNT_W'(ENTRIES);

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_MERGE  = 2'd1,
        OP_QUERY  = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_IGNORED    = 3'd1,
        ST_TOO_LARGE  = 3'd2,
        ST_MUTUAL_BAD = 3'd3,
        ST_FULL       = 3'd4,
        ST_RANGE      = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        K_NOTE,
        K_FRESH,
        K_COPY,
        K_QUERY,
        K_MERGE
    } kind_t;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [IDX_W-1:0] first_index;
        logic [IDX_W-1:0] second_index;
    } in_t;

    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic [CNT_W-1:0]   entry_count;
        logic [CNT_W-1:0]   label_count;
        logic [2:0]         status;
    } out_t;

    typedef struct packed {
        kind_t              kind;
        logic [IDX_W-1:0]   first;
        logic [IDX_W-1:0]   second;
        logic [LABEL_W-1:0] label;
        logic [CNT_W-1:0]   entry_count;
        logic [CNT_W-1:0]   label_count;
        status_t            status;
    } cmd_t;

endpackage

### design/qflt_front.sv
// Front end: checks each beat against the counters and turns it into a table command.
module qflt_front (
    input  logic          clk,
    input  logic          rst_n,
    input  qflt_pkg::in_t item,
    input  logic          accept,
    output qflt_pkg::cmd_t cmd
);
    import qflt_pkg::*;

    logic [CNT_W-1:0] entries_reg;
    logic [CNT_W-1:0] entries_next;
    logic [CNT_W-1:0] next_label_reg;
    logic [CNT_W-1:0] next_label_next;
    logic [CNT_W-1:0] a_ext;
    logic [CNT_W-1:0] b_ext;

    assign a_ext = {1'b0, item.first_index};
    assign b_ext = {1'b0, item.second_index};

    always_comb
    begin
        entries_next    = entries_reg;
        next_label_next = next_label_reg;
        cmd.kind        = K_NOTE;
        cmd.first       = item.first_index;
        cmd.second      = item.second_index;
        cmd.label       = '0;
        cmd.status      = ST_OK;
        unique case (item.opcode)
            OP_APPEND:
            begin
                if (a_ext < entries_reg)
                begin
                    cmd.status = ST_IGNORED;
                end
                else if (a_ext > entries_reg)
                begin
                    cmd.status = ST_TOO_LARGE;
                end
                else if (entries_reg >= ENTRIES_CNT)
                begin
                    cmd.status = ST_FULL;
                end
                else if (b_ext == entries_reg)
                begin
                    cmd.kind        = K_FRESH;
                    cmd.label       = next_label_reg[LABEL_W-1:0];
                    next_label_next = next_label_reg + CNT_W'(1);
                    entries_next    = entries_reg + CNT_W'(1);
                end
                else if (b_ext < entries_reg)
                begin
                    cmd.kind     = K_COPY;
                    entries_next = entries_reg + CNT_W'(1);
                end
                else
                begin
                    cmd.status = ST_MUTUAL_BAD;
                end
            end
            OP_MERGE:
            begin
                if (a_ext >= entries_reg || b_ext >= entries_reg)
                begin
                    cmd.status = ST_RANGE;
                end
                else
                begin
                    cmd.kind = K_MERGE;
                end
            end
            OP_QUERY:
            begin
                if (a_ext >= entries_reg)
                begin
                    cmd.status = ST_RANGE;
                end
                else
                begin
                    cmd.kind = K_QUERY;
                end
            end
            default:
            begin
                cmd.status = ST_OK;
            end
        endcase
        cmd.entry_count = entries_next;
        cmd.label_count = next_label_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg    <= '0;
            next_label_reg <= '0;
        end
        else if (accept)
        begin
            entries_reg    <= entries_next;
            next_label_reg <= next_label_next;
        end
    end

endmodule

### design/qflt_cmd_fifo.sv
// Short command queue between the front end and the table engine.
module qflt_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  qflt_pkg::cmd_t wr_data,
    output logic           full,
    input  logic           rd_en,
    output qflt_pkg::cmd_t rd_data,
    output logic           empty
);
    import qflt_pkg::*;

    cmd_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_wr;
    logic              do_rd;

    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

### design/qflt_engine.sv
// Table engine: owns the label memory, runs commands in order and holds the result register.
module qflt_engine (
    input  logic           clk,
    input  logic           rst_n,
    input  qflt_pkg::cmd_t q_cmd,
    input  logic           q_empty,
    output logic           q_pop,
    output qflt_pkg::out_t result,
    output logic           empty,
    input  logic           pop
);
    import qflt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_KEEP,
        S_GONE,
        S_SCAN,
        S_DONE
    } state_t;

    logic [LABEL_W-1:0] mem [ENTRIES];
    logic [LABEL_W-1:0] rd_data_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_wa;
    logic [LABEL_W-1:0] mem_wd;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_ra;

    state_t             state_reg;
    state_t             state_next;
    cmd_t               cmd_reg;
    cmd_t               cmd_next;
    logic [LABEL_W-1:0] keep_reg;
    logic [LABEL_W-1:0] keep_next;
    logic [LABEL_W-1:0] gone_reg;
    logic [LABEL_W-1:0] gone_next;
    logic [CNT_W-1:0]   scan_idx_reg;
    logic [CNT_W-1:0]   scan_idx_next;
    logic [IDX_W-1:0]   scan_addr_reg;
    logic [IDX_W-1:0]   scan_addr_next;
    out_t               res_reg;
    out_t               res_next;
    out_t               out_reg;
    out_t               out_next;
    logic               out_valid_reg;
    logic               out_valid_next;

    assign result = out_reg;
    assign empty  = !out_valid_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        keep_next      = keep_reg;
        gone_next      = gone_reg;
        scan_idx_next  = scan_idx_reg;
        scan_addr_next = scan_addr_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_wa         = '0;
        mem_wd         = '0;
        mem_re         = 1'b0;
        mem_ra         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop                = 1'b1;
                    cmd_next             = q_cmd;
                    res_next.label       = '0;
                    res_next.entry_count = q_cmd.entry_count;
                    res_next.label_count = q_cmd.label_count;
                    res_next.status      = q_cmd.status;
                    unique case (q_cmd.kind)
                        K_FRESH:
                        begin
                            mem_we         = 1'b1;
                            mem_wa         = q_cmd.first;
                            mem_wd         = q_cmd.label;
                            res_next.label = q_cmd.label;
                            state_next     = S_DONE;
                        end
                        K_COPY:
                        begin
                            mem_re     = 1'b1;
                            mem_ra     = q_cmd.second;
                            state_next = S_READ;
                        end
                        K_QUERY:
                        begin
                            mem_re     = 1'b1;
                            mem_ra     = q_cmd.first;
                            state_next = S_READ;
                        end
                        K_MERGE:
                        begin
                            mem_re     = 1'b1;
                            mem_ra     = q_cmd.first;
                            state_next = S_KEEP;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                res_next.label = rd_data_reg;
                if (cmd_reg.kind == K_COPY)
                begin
                    mem_we = 1'b1;
                    mem_wa = cmd_reg.first;
                    mem_wd = rd_data_reg;
                end
                state_next = S_DONE;
            end
            S_KEEP:
            begin
                keep_next  = rd_data_reg;
                mem_re     = 1'b1;
                mem_ra     = cmd_reg.second;
                state_next = S_GONE;
            end
            S_GONE:
            begin
                gone_next      = rd_data_reg;
                mem_re         = 1'b1;
                mem_ra         = '0;
                scan_addr_next = '0;
                scan_idx_next  = CNT_W'(1);
                state_next     = S_SCAN;
            end
            S_SCAN:
            begin
                if (rd_data_reg == gone_reg)
                begin
                    mem_we = 1'b1;
                    mem_wa = scan_addr_reg;
                    mem_wd = keep_reg;
                end
                if (scan_idx_reg == cmd_reg.entry_count)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    mem_re         = 1'b1;
                    mem_ra         = scan_idx_reg[IDX_W-1:0];
                    scan_addr_next = scan_idx_reg[IDX_W-1:0];
                    scan_idx_next  = scan_idx_reg + CNT_W'(1);
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cmd_reg       <= cmd_next;
            keep_reg      <= keep_next;
            gone_reg      <= gone_next;
            scan_idx_reg  <= scan_idx_next;
            scan_addr_reg <= scan_addr_next;
            res_reg       <= res_next;
            out_reg       <= out_next;
        end
    end

endmodule

### design/quick_find_label_table.sv
// Top level of the quick-find equivalence label table.
// A beat is taken whenever the four-deep command queue has room; the front end
// checks it against the entry and label counters at once, so rejected beats and
// the counts never wait on the table. The engine then works on one command at a
// time over a single label memory with one write and one registered read port;
// a merge reads every entry in use once through the read port. The result
// register lets the next command run while a finished beat waits to be popped.
module quick_find_label_table (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  qflt_pkg::in_t item,
    output logic          empty,
    input  logic          pop,
    output qflt_pkg::out_t result
);
    import qflt_pkg::*;

    `include "quick_find_label_table_macros.svh"

    cmd_t front_cmd;
    cmd_t q_cmd;
    logic q_full;
    logic q_empty;
    logic q_pop;
    logic accept;

    assign full   = q_full;
    assign accept = push && !q_full;

    qflt_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .accept (accept),
        .cmd    (front_cmd)
    );

    qflt_cmd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data (front_cmd),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_cmd),
        .empty   (q_empty)
    );

    qflt_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_cmd   (q_cmd),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

    `QFLT_ASSERT_IMPLIES(a_label_zero_on_error, clk, rst_n, !empty && result.status != ST_OK, result.label == '0)
    `QFLT_ASSERT_IMPLIES(a_counts_bounded, clk, rst_n, !empty, result.label_count <= result.entry_count && result.entry_count <= ENTRIES_CNT)
    `QFLT_ASSERT_NEXT(a_accept_queued, clk, rst_n, accept, !q_empty)

endmodule
